/* rtl/alu_pkg.sv */
package alu_pkg;

    localparam int DataWidth = 32;

    typedef enum logic [3:0] {
        ACT_MOV = 4'd0,
        ACT_ADD = 4'd1,
        ACT_SUB = 4'd2,
        ACT_MUL = 4'd3,
        ACT_DIV = 4'd4,
        ACT_CMP = 4'd5,
        ACT_AND = 4'd6,
        ACT_OR  = 4'd7,
        ACT_XOR = 4'd8,
        ACT_NOT = 4'd9,
        ACT_SHL = 4'd10,
        ACT_SHR = 4'd11,
        ACT_SAR = 4'd12
    } action_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [3:0]           action;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
        logic                 is_div;
        logic                 div_zero;
        logic                 div_ovf;
        logic                 known;
    } op_t;

    typedef struct packed {
        logic [DataWidth-1:0] result;
        logic                 result_valid;
        logic [DataWidth-1:0] remainder;
        logic                 remainder_valid;
        logic [3:0]           flags;
        logic                 divide_by_zero;
    } res_t;

endpackage

/* rtl/alu_front.sv */
module alu_front import alu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_action,
    input  logic [DataWidth-1:0] s_operand_a,
    input  logic [DataWidth-1:0] s_operand_b,
    output logic                 q_valid,
    input  logic                 q_ready,
    output op_t                  q_op
);

    localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

    op_t  slot_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    op_t  cls;
    logic push, pop;

    // classify incoming item
    always_comb begin
        cls.action   = s_action;
        cls.a        = s_operand_a;
        cls.b        = s_operand_b;
        cls.is_div   = (s_action == ACT_DIV);
        cls.div_zero = (s_operand_b == '0);
        cls.div_ovf  = (s_operand_a == MinVal) && (s_operand_b == '1);
        cls.known    = (s_action <= ACT_SAR);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // two-entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= cls;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/alu_back.sv */
module alu_back import alu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  op_t  q_op,
    output logic r_valid,
    input  logic r_ready,
    output res_t r_res
);

    localparam int CntW = $clog2(DataWidth + 1);
    localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_OUT} state_t;

    state_t state_reg;
    op_t    op_reg;
    logic [3:0] flags_reg;
    res_t   res_reg;
    logic [DataWidth-1:0] rem_reg, quo_reg, div_mag_reg;
    logic [CntW-1:0] cnt_reg;
    logic [2*DataWidth-1:0] prod_reg;

    logic [DataWidth-1:0] a, b, r;
    logic [DataWidth:0]   sum, dif, trial;
    logic c, v, rv;
    logic [DataWidth-1:0] q_fin, rm_fin;
    logic signed [2*DataWidth-1:0] prod_s;

    assign a = op_reg.a;
    assign b = op_reg.b;
    assign sum = {1'b0, a} + {1'b0, b};
    assign dif = {1'b0, a} - {1'b0, b};
    assign trial = {rem_reg, quo_reg[DataWidth-1]} - {1'b0, div_mag_reg};
    assign q_fin  = (a[DataWidth-1] ^ b[DataWidth-1]) ? -quo_reg : quo_reg;
    assign rm_fin = a[DataWidth-1] ? -rem_reg : rem_reg;
    assign prod_s = $signed(prod_reg);

    // simple ops: combinational result and carry/overflow
    always_comb begin
        logic sh_in, sh_c;
        logic [DataWidth-1:0] amt;
        amt   = b;
        sh_in = ($signed(b) >= 0) && (b < DataWidth);
        sh_c  = ($signed(b) >= 1) && (b <= DataWidth);
        r = '0; c = 1'b0; v = 1'b0; rv = 1'b1;
        case (op_reg.action)
            ACT_MOV: r = b;
            ACT_ADD: begin
                r = sum[DataWidth-1:0];
                c = sum[DataWidth];
                v = (a[DataWidth-1] == b[DataWidth-1]) && (r[DataWidth-1] != a[DataWidth-1]);
            end
            ACT_SUB, ACT_CMP: begin
                r = dif[DataWidth-1:0];
                c = dif[DataWidth];
                v = (a[DataWidth-1] != b[DataWidth-1]) && (r[DataWidth-1] != a[DataWidth-1]);
                rv = (op_reg.action == ACT_SUB);
            end
            ACT_AND: r = a & b;
            ACT_OR:  r = a | b;
            ACT_XOR: r = a ^ b;
            ACT_NOT: r = ~b;
            ACT_SHL: begin
                r = sh_in ? (a << amt) : '0;
                if (sh_c) begin
                    c = a[DataWidth - amt];
                    v = a[DataWidth-1] ^ r[DataWidth-1];
                end
            end
            ACT_SHR, ACT_SAR: begin
                if (op_reg.action == ACT_SAR)
                    r = sh_in ? DataWidth'($signed(a) >>> amt) : {DataWidth{a[DataWidth-1]}};
                else
                    r = sh_in ? (a >> amt) : '0;
                if (sh_c) c = a[amt - 1];
            end
            default: rv = 1'b0;
        endcase
    end

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = (state_reg == ST_OUT);
    assign r_res   = res_reg;

    // sequencer: one quotient bit per cycle for DIV; the MUL product is registered on capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flags_reg <= 4'd0;
        end else begin
            case (state_reg)
                ST_IDLE: if (q_valid) begin
                    op_reg <= q_op;
                    prod_reg <= $signed(q_op.a) * $signed(q_op.b);
                    if (q_op.action == ACT_MUL) state_reg <= ST_MUL;
                    else if (q_op.is_div && !q_op.div_zero && !q_op.div_ovf) begin
                        rem_reg     <= '0;
                        quo_reg     <= q_op.a[DataWidth-1] ? -q_op.a : q_op.a;
                        div_mag_reg <= q_op.b[DataWidth-1] ? -q_op.b : q_op.b;
                        cnt_reg     <= CntW'(DataWidth);
                        state_reg   <= ST_DIV;
                    end else begin
                        // other ops, DIV by zero or overflow included, finish via the ST_MUL path
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    res_reg.remainder       <= '0;
                    res_reg.remainder_valid <= 1'b0;
                    res_reg.divide_by_zero  <= 1'b0;
                    if (op_reg.action == ACT_MUL) begin
                        res_reg.result       <= prod_reg[DataWidth-1:0];
                        res_reg.result_valid <= 1'b1;
                        res_reg.flags <= {prod_reg[DataWidth-1], prod_reg[DataWidth-1:0] == '0,
                            {2{prod_s != (2*DataWidth)'($signed(prod_reg[DataWidth-1:0]))}}};
                        flags_reg <= {prod_reg[DataWidth-1], prod_reg[DataWidth-1:0] == '0,
                            {2{prod_s != (2*DataWidth)'($signed(prod_reg[DataWidth-1:0]))}}};
                    end else if (op_reg.is_div) begin
                        res_reg.divide_by_zero <= op_reg.div_zero;
                        res_reg.result <= op_reg.div_zero ? '0 : MinVal;
                        res_reg.result_valid <= !op_reg.div_zero;
                        res_reg.remainder_valid <= !op_reg.div_zero;
                        if (op_reg.div_zero) res_reg.flags <= flags_reg;
                        else begin
                            res_reg.flags <= 4'b1001;
                            flags_reg     <= 4'b1001;
                        end
                    end else if (op_reg.known) begin
                        res_reg.result       <= r;
                        res_reg.result_valid <= rv;
                        res_reg.flags <= {r[DataWidth-1], r == '0, c, v};
                        flags_reg     <= {r[DataWidth-1], r == '0, c, v};
                    end else begin
                        res_reg.result       <= '0;
                        res_reg.result_valid <= 1'b0;
                        res_reg.flags        <= flags_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_DIV: begin
                    if (cnt_reg != '0) begin
                        if (!trial[DataWidth]) begin
                            rem_reg <= trial[DataWidth-1:0];
                            quo_reg <= {quo_reg[DataWidth-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[DataWidth-2:0], quo_reg[DataWidth-1]};
                            quo_reg <= {quo_reg[DataWidth-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end else begin
                        res_reg.result          <= q_fin;
                        res_reg.result_valid    <= 1'b1;
                        res_reg.remainder       <= rm_fin;
                        res_reg.remainder_valid <= 1'b1;
                        res_reg.divide_by_zero  <= 1'b0;
                        res_reg.flags <= {q_fin[DataWidth-1], q_fin == '0, 2'b00};
                        flags_reg     <= {q_fin[DataWidth-1], q_fin == '0, 2'b00};
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: if (r_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/alu_with_nzcv_flags.sv */
// Channel | valid   | ready   | payload
// input   | s_valid | s_ready | s_action, s_operand_a, s_operand_b
// result  | m_valid | m_ready | m_result ... m_divide_by_zero
// Most items pass ST_MUL and ST_OUT in the back end; DIV runs through ST_DIV (one
// quotient bit per cycle in the shift-subtract divider), which sets the worst-case rate.
// A two-entry queue lets the front keep accepting while the back is busy.
// aresetn is synchronous, active low; it clears the flags to zero.
// The result holds in its register while m_ready is low.
module alu_with_nzcv_flags import alu_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_action,
    input  logic [DataWidth-1:0] s_operand_a,
    input  logic [DataWidth-1:0] s_operand_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DataWidth-1:0] m_result,
    output logic                 m_result_valid,
    output logic [DataWidth-1:0] m_remainder,
    output logic                 m_remainder_valid,
    output logic                 m_flag_n,
    output logic                 m_flag_z,
    output logic                 m_flag_c,
    output logic                 m_flag_v,
    output logic                 m_divide_by_zero
);

    logic q_valid, q_ready;
    op_t  q_op;
    res_t res;

    alu_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .s_operand_a, .s_operand_b,
        .q_valid, .q_ready, .q_op
    );

    alu_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_op,
        .r_valid(m_valid), .r_ready(m_ready), .r_res(res)
    );

    assign m_result          = res.result;
    assign m_result_valid    = res.result_valid;
    assign m_remainder       = res.remainder;
    assign m_remainder_valid = res.remainder_valid;
    assign {m_flag_n, m_flag_z, m_flag_c, m_flag_v} = res.flags;
    assign m_divide_by_zero  = res.divide_by_zero;

endmodule

/* tb/sv/tb_top.sv */
module tb_top import alu_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchLimit = 20000;
    localparam int DrainCycles = 80;

    typedef struct packed {
        logic [31:0] result;
        logic        result_valid;
        logic [31:0] remainder;
        logic        remainder_valid;
        logic        n;
        logic        z;
        logic        c;
        logic        v;
        logic        dz;
    } alu_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [3:0]  s_action = '0;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result;
    logic        m_result_valid;
    logic [31:0] m_remainder;
    logic        m_remainder_valid;
    logic        m_flag_n;
    logic        m_flag_z;
    logic        m_flag_c;
    logic        m_flag_v;
    logic        m_divide_by_zero;

    alu_out_t    expected_q[$];
    logic [3:0]  nzcv_model = '0;
    int          error_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          sink_mode = 0;     // 0 random stalls, 1 always ready, 2 long hold-off
    int          src_gap_mode = 0;  // 0 random gaps, 1 back to back

    always #1 aclk = ~aclk;

    alu_with_nzcv_flags i_dut (.*);

    // work out one item and update the flag model
    function automatic alu_out_t alu_predict(logic [3:0] act, logic [31:0] a, logic [31:0] b);
        alu_out_t    o;
        logic [32:0] sum;
        logic signed [63:0] prod;
        logic [31:0] r;
        logic        c;
        logic        v;
        logic        upd;
        int signed   amt;
        r = '0;
        c = 1'b0;
        v = 1'b0;
        upd = 1'b1;
        o = '0;
        o.result_valid = 1'b1;
        amt = $signed(b);
        case (act)
            ACT_MOV: r = b;
            ACT_ADD: begin
                sum = {1'b0, a} + {1'b0, b};
                r = sum[31:0];
                c = sum[32];
                v = (a[31] == b[31]) && (r[31] != a[31]);
            end
            ACT_SUB, ACT_CMP: begin
                r = a - b;
                c = a < b;
                v = (a[31] != b[31]) && (r[31] != a[31]);
                if (act == ACT_CMP) o.result_valid = 1'b0;
            end
            ACT_MUL: begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                r = prod[31:0];
                c = prod != {{32{r[31]}}, r};
                v = c;
            end
            ACT_DIV: begin
                if (b == '0) begin
                    o.dz = 1'b1;
                    o.result_valid = 1'b0;
                    upd = 1'b0;
                end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                    r = 32'h8000_0000;
                    v = 1'b1;
                    o.remainder_valid = 1'b1;
                end else begin
                    r = $signed(a) / $signed(b);
                    o.remainder = $signed(a) % $signed(b);
                    o.remainder_valid = 1'b1;
                end
            end
            ACT_AND: r = a & b;
            ACT_OR:  r = a | b;
            ACT_XOR: r = a ^ b;
            ACT_NOT: r = ~b;
            ACT_SHL: begin
                r = (amt >= 0 && amt < 32) ? a << amt : '0;
                if (amt >= 1 && amt <= 32) begin
                    c = a[32 - amt];
                    v = a[31] ^ r[31];
                end
            end
            ACT_SHR, ACT_SAR: begin
                if (amt >= 0 && amt < 32)
                    r = (act == ACT_SAR) ? $unsigned($signed(a) >>> amt) : a >> amt;
                else
                    r = (act == ACT_SAR && a[31]) ? '1 : '0;
                if (amt >= 1 && amt <= 32) c = a[amt - 1];
            end
            default: begin
                o.result_valid = 1'b0;
                upd = 1'b0;
            end
        endcase
        if (upd) nzcv_model = {r[31], r == '0, c, v};
        o.result = r;
        {o.n, o.z, o.c, o.v} = nzcv_model;
        return o;
    endfunction

    // offer one item and hold it until accepted; valid drops only before a gap
    task automatic alu_send(logic [3:0] act, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = 0;
        if (src_gap_mode == 0) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                                 : $urandom_range(0, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk iff s_ready);
        expected_q.push_back(alu_predict(act, a, b));
        items_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 40) - 4;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_shift();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(30, 34);
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    // extremes and special cases for each operation
    task automatic test_directed();
        alu_send(ACT_MOV, 32'h0, 32'h8000_0000);
        alu_send(ACT_ADD, 32'h7FFF_FFFF, 32'h1);
        alu_send(ACT_ADD, 32'hFFFF_FFFF, 32'h1);
        alu_send(ACT_SUB, 32'h8000_0000, 32'h1);
        alu_send(ACT_CMP, 32'h0, 32'h1);
        alu_send(ACT_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
        alu_send(ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        alu_send(ACT_DIV, 32'hFFFF_FFF9, 32'h2);
        alu_send(ACT_DIV, 32'h1234, 32'h0);
        alu_send(ACT_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        alu_send(ACT_AND, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
        alu_send(ACT_OR, 32'h0, 32'h0);
        alu_send(ACT_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        alu_send(ACT_NOT, 32'h0, 32'h0);
        alu_send(ACT_SHL, 32'hC000_0001, 32'd1);
        alu_send(ACT_SHL, 32'h1, 32'd32);
        alu_send(ACT_SHL, 32'h1, 32'hFFFF_FFFF);
        alu_send(ACT_SHR, 32'h8000_0001, 32'd31);
        alu_send(ACT_SHR, 32'h8000_0001, 32'd32);
        alu_send(ACT_SAR, 32'h8000_0000, 32'd40);
        alu_send(ACT_SAR, 32'h8000_0000, 32'd0);
        alu_send(4'd13, 32'h5, 32'h5);
        alu_send(4'd15, 32'hFFFF_FFFF, 32'h0);
    endtask

    // random items over all codes, with operand corner values
    task automatic test_random(int count);
        logic [3:0]  act;
        logic [31:0] b;
        repeat (count) begin
            act = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
            b = (act inside {ACT_SHL, ACT_SHR, ACT_SAR}) ? rand_shift() : rand_operand();
            if (act == ACT_DIV && $urandom_range(0, 15) == 0) b = '0;
            alu_send(act, rand_operand(), b);
        end
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        sink_mode = 2;
        src_gap_mode = 1;
        test_random(12);
        wait_all_results();
        sink_mode = 0;
        src_gap_mode = 0;
    endtask

    // full-rate stretch, then a pause until everything drains
    task automatic test_streaming();
        sink_mode = 1;
        src_gap_mode = 1;
        test_random(200);
        wait_all_results();
        sink_mode = 0;
        src_gap_mode = 0;
    endtask

    // result sink: always ready, random stalls or a long hold-off
    initial begin
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_mode == 2) begin
                m_ready <= 1'b0;
                hold = 300;
                while (hold > 0) begin
                    @(posedge aclk);
                    hold--;
                end
                m_ready <= 1'b1;
                while (sink_mode == 2) @(posedge aclk);
            end else if (sink_mode == 1 || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
                repeat (hold) @(posedge aclk);
            end
        end
    end

    // check each result against the oldest expectation
    always @(posedge aclk) begin
        alu_out_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                exp_item = expected_q.pop_front();
                if (m_result !== exp_item.result) begin
                    $error("result: expected %h, got %h", exp_item.result, m_result);
                    error_count++;
                end
                if (m_result_valid !== exp_item.result_valid) begin
                    $error("result_valid: expected %b, got %b", exp_item.result_valid,
                           m_result_valid);
                    error_count++;
                end
                if (m_remainder !== exp_item.remainder) begin
                    $error("remainder: expected %h, got %h", exp_item.remainder, m_remainder);
                    error_count++;
                end
                if (m_remainder_valid !== exp_item.remainder_valid) begin
                    $error("remainder_valid: expected %b, got %b", exp_item.remainder_valid,
                           m_remainder_valid);
                    error_count++;
                end
                if (m_flag_n !== exp_item.n) begin
                    $error("flag_n: expected %b, got %b", exp_item.n, m_flag_n);
                    error_count++;
                end
                if (m_flag_z !== exp_item.z) begin
                    $error("flag_z: expected %b, got %b", exp_item.z, m_flag_z);
                    error_count++;
                end
                if (m_flag_c !== exp_item.c) begin
                    $error("flag_c: expected %b, got %b", exp_item.c, m_flag_c);
                    error_count++;
                end
                if (m_flag_v !== exp_item.v) begin
                    $error("flag_v: expected %b, got %b", exp_item.v, m_flag_v);
                    error_count++;
                end
                if (m_divide_by_zero !== exp_item.dz) begin
                    $error("divide_by_zero: expected %b, got %b", exp_item.dz,
                           m_divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_streaming();
        test_random(1500);
        wait_all_results();
        repeat (DrainCycles) @(posedge aclk);
        $display("Sent %0d items over all opcodes, corner operands, shifts and divides;",
                 items_sent);
        $display("checked %0d results under stalls and a long receiver hold-off.",
                 results_seen);
        if (error_count == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/alu_pkg.sv
rtl/alu_front.sv
rtl/alu_back.sv
rtl/alu_with_nzcv_flags.sv
tb/sv/tb_top.sv
